// File: sv/u16to8_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u16to8_pkg
// shared types, constants and the utf-8 encoder for the utf-16 transcoder
// ---------------------------------------------------------------------------
package u16to8_pkg;

  localparam int UNIT_W   = 16;
  localparam int BYTE_W   = 8;
  localparam int CAP_W    = 16;
  localparam int CHAR_W   = 21;
  localparam int NCHAR_W  = 3;
  localparam int HIGH_W   = 10;

  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic [CAP_W-1:0]  CAP_RESET  = 16'hffff;
  localparam logic [UNIT_W-1:0] HI_FIRST   = 16'hd800;
  localparam logic [UNIT_W-1:0] HI_LAST    = 16'hdbff;
  localparam logic [UNIT_W-1:0] LO_FIRST   = 16'hdc00;
  localparam logic [UNIT_W-1:0] LO_LAST    = 16'hdfff;
  localparam logic [CHAR_W-1:0] SUPP_BASE  = 21'h010000;
  localparam logic [CHAR_W-1:0] REPL_CHAR  = 21'h00fffd;
  localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

  typedef logic [3:0][BYTE_W-1:0] byte_vec_t;

  typedef struct packed {
    byte_vec_t          bytes;
    logic [NCHAR_W-1:0] n;
  } enc_t;

  // one queue entry: the character bytes and an optional terminator after them
  typedef struct packed {
    byte_vec_t          bytes;
    logic [NCHAR_W-1:0] nchar;
    logic               eos;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } job_wr_t;

  function automatic enc_t utf8_encode(input logic [CHAR_W-1:0] c);
    enc_t e;
    e.bytes = '0;
    if (c < 21'h000080) begin
      e.bytes[0] = {1'b0, c[6:0]};
      e.n        = 3'd1;
    end else if (c < 21'h000800) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.n        = 3'd2;
    end else if (c < 21'h010000) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.n        = 3'd3;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.n        = 3'd4;
    end
    return e;
  endfunction

endpackage
`default_nettype wire

// File: sv/utf16_to_utf8_transcoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// utf-16 code units in, utf-8 bytes out, with capacity limit and terminator
// ---------------------------------------------------------------------------
// A code unit is taken in the cycle it is pushed while full is low; the front
// part pairs surrogates, encodes the character and checks it against the
// capacity in that cycle and writes the result into a four-entry job queue.
// The back part drains that queue at one output word per cycle while out_pop
// keeps the output register free, so each unit holds the output for as many
// words as it yields bytes (one to four; a held high surrogate or a unit
// dropped after a stop yields none). Sustained input rate is therefore set by
// the single byte lane at the output register; full rises only when the job
// queue is full. Capacity is written through the cfg channel, always ready;
// the user must write it while the block is idle; the block does not check.
// ---------------------------------------------------------------------------
module utf16_to_utf8_transcoder (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_push,
  output logic                            in_full,
  input  wire  [u16to8_pkg::UNIT_W-1:0]   in_code_unit,
  output logic                            out_empty,
  input  wire                             out_pop,
  output logic [u16to8_pkg::BYTE_W-1:0]   out_byte,
  output logic                            out_last_of_run,
  output logic                            out_end_of_string,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [u16to8_pkg::CAP_W-1:0]    cfg_out_capacity
);
  import u16to8_pkg::*;

  job_wr_t q_wr;
  job_t    q_data;
  logic    q_full, q_empty, q_pop;

  u16to8_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_code_unit     (in_code_unit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_out_capacity (cfg_out_capacity),
    .q_full           (q_full),
    .q_wr             (q_wr)
  );

  u16to8_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  u16to8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_string (out_end_of_string)
  );

endmodule
`default_nettype wire

// File: sv/u16to8_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u16to8_front
// accepts code units, pairs surrogates, encodes and checks capacity
// ---------------------------------------------------------------------------
module u16to8_front (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_push,
  output logic                              in_full,
  input  wire  [u16to8_pkg::UNIT_W-1:0]     in_code_unit,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [u16to8_pkg::CAP_W-1:0]      cfg_out_capacity,
  input  wire                               q_full,
  output u16to8_pkg::job_wr_t               q_wr
);
  import u16to8_pkg::*;

  logic [CAP_W-1:0]  capacity_r;
  logic [HIGH_W-1:0] pending_high_r, pending_high_nxt;
  logic              pending_valid_r, pending_valid_nxt;
  logic [CAP_W-1:0]  bytes_written_r, bytes_written_nxt;
  logic              stopped_r, stopped_nxt;

  logic              accept;
  logic              is_zero, is_hi, is_lo;
  logic              want;
  logic [CHAR_W-1:0] ch;
  logic [CHAR_W-1:0] pair;
  enc_t              enc;
  logic [CAP_W:0]    sum;
  logic              fits, emit, fail;

  assign in_full   = q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;

  assign is_zero = (in_code_unit == '0);
  assign is_hi   = (in_code_unit >= HI_FIRST) && (in_code_unit <= HI_LAST);
  assign is_lo   = (in_code_unit >= LO_FIRST) && (in_code_unit <= LO_LAST);
  assign pair    = {1'b0, pending_high_r, in_code_unit[HIGH_W-1:0]} + SUPP_BASE;

  always_comb begin
    want = 1'b0;
    ch   = REPL_CHAR;
    priority if (is_zero) begin
      want = pending_valid_r;
    end else if (stopped_r) begin
      want = 1'b0;
    end else if (pending_valid_r) begin
      want = 1'b1;
      ch   = is_lo ? pair : REPL_CHAR;
    end else if (is_hi) begin
      want = 1'b0;
    end else if (is_lo) begin
      want = 1'b1;
    end else begin
      want = 1'b1;
      ch   = {{(CHAR_W-UNIT_W){1'b0}}, in_code_unit};
    end
  end

  assign enc  = utf8_encode(ch);
  assign sum  = {1'b0, bytes_written_r} + {{(CAP_W+1-NCHAR_W){1'b0}}, enc.n};
  assign fits = sum < {1'b0, capacity_r};
  assign emit = want && !stopped_r && fits;
  assign fail = want && !stopped_r && !fits;

  always_comb begin
    q_wr.push      = accept && (emit || is_zero);
    q_wr.job.bytes = enc.bytes;
    q_wr.job.nchar = emit ? enc.n : '0;
    q_wr.job.eos   = is_zero;
  end

  always_comb begin
    pending_high_nxt  = pending_high_r;
    pending_valid_nxt = pending_valid_r;
    bytes_written_nxt = bytes_written_r;
    stopped_nxt       = stopped_r;
    if (accept) begin
      priority if (is_zero) begin
        pending_high_nxt  = '0;
        pending_valid_nxt = 1'b0;
        bytes_written_nxt = '0;
        stopped_nxt       = 1'b0;
      end else if (!stopped_r) begin
        pending_valid_nxt = !pending_valid_r && is_hi;
        pending_high_nxt  = (!pending_valid_r && is_hi) ? in_code_unit[HIGH_W-1:0] : '0;
        if (emit) begin
          bytes_written_nxt = sum[CAP_W-1:0];
        end
        if (fail) begin
          stopped_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r      <= CAP_RESET;
      pending_high_r  <= '0;
      pending_valid_r <= 1'b0;
      bytes_written_r <= '0;
      stopped_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_out_capacity;
      end
      pending_high_r  <= pending_high_nxt;
      pending_valid_r <= pending_valid_nxt;
      bytes_written_r <= bytes_written_nxt;
      stopped_r       <= stopped_nxt;
    end
  end

`ifndef SYNTHESIS
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_zero |=> !pending_valid_r && !stopped_r && (bytes_written_r == '0))
    else $error("terminator did not clear string state");
  a_stopped_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !is_zero && stopped_r |-> !q_wr.push)
    else $error("word produced while output stopped");
`endif

endmodule
`default_nettype wire

// File: sv/u16to8_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u16to8_queue
// small job queue between the front and back parts
// ---------------------------------------------------------------------------
module u16to8_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  u16to8_pkg::job_wr_t  q_wr,
  output logic                 q_full,
  input  wire                  q_pop,
  output logic                 q_empty,
  output u16to8_pkg::job_t     q_data
);
  import u16to8_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = q_wr.push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count past depth");
`endif

endmodule
`default_nettype wire

// File: sv/u16to8_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// u16to8_back
// serialises queued jobs into output words, one byte per cycle unless stalled
// ---------------------------------------------------------------------------
module u16to8_back (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             q_empty,
  input  u16to8_pkg::job_t                q_data,
  output logic                            q_pop,
  output logic                            out_empty,
  input  wire                             out_pop,
  output logic [u16to8_pkg::BYTE_W-1:0]   out_byte,
  output logic                            out_last_of_run,
  output logic                            out_end_of_string
);
  import u16to8_pkg::*;

  job_t               job_r;
  logic               job_valid_r;
  logic [1:0]         idx_r;
  logic               out_valid_r;
  logic [BYTE_W-1:0]  byte_r;
  logic               last_r, eos_r;

  logic [NCHAR_W-1:0] total;
  logic               cur_eos, cur_last;
  logic [BYTE_W-1:0]  cur_byte;
  logic               out_load, job_done, job_take;

  assign total    = job_r.nchar + {{(NCHAR_W-1){1'b0}}, job_r.eos};
  assign cur_eos  = ({1'b0, idx_r} >= job_r.nchar);
  assign cur_byte = cur_eos ? NUL_BYTE : job_r.bytes[idx_r];
  assign cur_last = ({1'b0, idx_r} == total - 1'b1);

  assign out_load = job_valid_r && (!out_valid_r || out_pop);
  assign job_done = out_load && cur_last;
  assign job_take = !job_valid_r || job_done;
  assign q_pop    = job_take && !q_empty;

  assign out_empty         = !out_valid_r;
  assign out_byte          = byte_r;
  assign out_last_of_run   = last_r;
  assign out_end_of_string = eos_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_data;
    end
    if (out_load) begin
      byte_r <= cur_byte;
      last_r <= cur_last;
      eos_r  <= cur_eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (job_done) begin
        job_valid_r <= 1'b0;
      end else if (out_load) begin
        idx_r <= idx_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && eos_r |-> last_r)
    else $error("terminator word not marked last");
`endif

endmodule
`default_nettype wire
